/* rtl/dti_pkg.sv */
// ----------------------------------------------------------------------------
// dti_pkg
// Shared types and constants for the decision tree inference block:
// node entry layout, split decision result and action codes.
// ----------------------------------------------------------------------------
`default_nettype none

package dti_pkg;

    localparam int IDX_W     = 10;   // node / feature index field width
    localparam int FEAT_W    = 6;    // split feature field width
    localparam int DATA_W    = 32;   // Q16.16 words
    localparam int ACT_W     = 2;
    localparam int S_TDATA_W = 200;  // 198 payload bits padded to bytes
    localparam int M_TDATA_W = 48;   // 42 payload bits padded to bytes
    localparam int IDX_SPACE = 1 << IDX_W;

    typedef enum logic [ACT_W-1:0] {
        ACT_WR_NODE  = 2'd0,
        ACT_WR_FEAT  = 2'd1,
        ACT_CLASSIFY = 2'd2
    } t_action;

    typedef struct packed {
        logic              leaf;
        logic              categorical;
        logic [IDX_W-1:0]  left;
        logic [IDX_W-1:0]  right;
        logic [FEAT_W-1:0] feature;
        logic [DATA_W-1:0] threshold;
        logic [DATA_W-1:0] mask;
        logic [DATA_W-1:0] rate;
    } t_node;

    typedef struct packed {
        logic             fault;
        logic [IDX_W-1:0] next;
    } t_split;

endpackage

`default_nettype wire

/* rtl/decision_tree_inference.sv */
// ----------------------------------------------------------------------------
// decision_tree_inference
// Regression tree inference: node table load, sample load and tree walk
// with a Q16.16 leaf rate times exposure product.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: tuser carries the action (write node, write feature,
//   classify); tdata carries the node entry, feature value and exposure.
//   Master channel: one beat per classify with prediction and leaf index in
//   tdata and the fault flag in tuser. Writes produce no beat.
// Sequence: a node or feature write is stored as it is accepted. A classify
//   walks the tree from the root; each interior node costs a node table
//   read, then a feature read and split test in the shared split unit. The
//   leaf read, the multiply and the loading of the output register follow.
//   A fault ends the walk at once.
// Rate: one write per cycle while no classify is in progress; a new
//   classify is taken only once the previous result has been loaded for
//   output.
// The slave side is ready only while no classify is in progress; a waiting
//   result does not block writes, but a new result waits in the output
//   cycle until the master side has taken the previous beat.
// Reset (i_rst_n low, synchronous) clears the sequencer and the output
//   valid and holds the slave side not ready; table and feature contents
//   are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module decision_tree_inference #(
    parameter int MAX_NODES      = 1024,
    parameter int NUM_FEATURES   = 64,
    parameter int MAX_CATEGORIES = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // index, node_is_leaf, split_is_categorical, left_child, right_child,
    // split_feature, split_threshold, category_mask, leaf_rate,
    // feature_value, exposure, zero pad
    input  wire logic [dti_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // action
    input  wire logic [dti_pkg::ACT_W-1:0]       s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // prediction, leaf_index, zero pad
    output logic [dti_pkg::M_TDATA_W-1:0]        m_axis_tdata,
    // fault
    output logic                                 m_axis_tuser
);

    localparam int SW = $clog2(MAX_NODES + 1);
    localparam logic [SW-1:0] StepLimit = SW'(MAX_NODES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_NODE,
        S_TEST,
        S_MUL,
        S_OUT
    } t_state;

    t_state                      r_state;
    t_state                      n_state;
    logic [dti_pkg::IDX_W-1:0]   r_k;
    logic [SW-1:0]               r_steps;
    logic [dti_pkg::DATA_W-1:0]  r_exposure;
    logic [2*dti_pkg::DATA_W-1:0] r_prod;
    logic                        r_fault;
    logic                        r_out_valid;
    logic [dti_pkg::DATA_W-1:0]  r_out_pred;
    logic [dti_pkg::IDX_W-1:0]   r_out_leaf;
    logic                        r_out_fault;

    logic                        in_acc;
    dti_pkg::t_action            act;
    dti_pkg::t_node              wr_node;
    logic [dti_pkg::IDX_W-1:0]   in_index;
    logic [dti_pkg::DATA_W-1:0]  in_feat_value;
    logic [dti_pkg::DATA_W-1:0]  in_exposure;

    logic                        node_we;
    logic                        feat_we;
    logic                        node_re;
    logic [dti_pkg::IDX_W-1:0]   node_raddr;
    logic                        feat_re;
    dti_pkg::t_node              node;
    logic [dti_pkg::DATA_W-1:0]  feat_value;
    dti_pkg::t_split             split;
    logic                        step_lim;
    logic                        out_load;
    logic [dti_pkg::DATA_W-1:0]  sat_pred;

    assign s_axis_tready = i_rst_n && (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign act           = dti_pkg::t_action'(s_axis_tuser);

    assign in_index              = s_axis_tdata[9:0];
    assign wr_node.leaf          = s_axis_tdata[10];
    assign wr_node.categorical   = s_axis_tdata[11];
    assign wr_node.left          = s_axis_tdata[21:12];
    assign wr_node.right         = s_axis_tdata[31:22];
    assign wr_node.feature       = s_axis_tdata[37:32];
    assign wr_node.threshold     = s_axis_tdata[69:38];
    assign wr_node.mask          = s_axis_tdata[101:70];
    assign wr_node.rate          = s_axis_tdata[133:102];
    assign in_feat_value         = s_axis_tdata[165:134];
    assign in_exposure           = s_axis_tdata[197:166];

    assign node_we = in_acc && (act == dti_pkg::ACT_WR_NODE);
    assign feat_we = in_acc && (act == dti_pkg::ACT_WR_FEAT);

    dti_store #(
        .MAX_NODES    (MAX_NODES),
        .NUM_FEATURES (NUM_FEATURES)
    ) u_store (
        .i_clk        (i_clk),
        .i_node_we    (node_we),
        .i_node_waddr (in_index),
        .i_node_wdata (wr_node),
        .i_node_re    (node_re),
        .i_node_raddr (node_raddr),
        .o_node       (node),
        .i_feat_we    (feat_we),
        .i_feat_waddr (in_index),
        .i_feat_wdata (in_feat_value),
        .i_feat_re    (feat_re),
        .i_feat_raddr (node.feature),
        .o_feat_value (feat_value)
    );

    dti_split #(
        .MAX_NODES      (MAX_NODES),
        .MAX_CATEGORIES (MAX_CATEGORIES)
    ) u_split (
        .i_node  (node),
        .i_value (feat_value),
        .o_split (split)
    );

    assign step_lim = (r_steps == StepLimit);
    assign out_load = (r_state == S_OUT) && (!r_out_valid || m_axis_tready);
    assign sat_pred = (r_prod[63:48] != '0) ? '1 : r_prod[47:16];

    always_comb begin
        n_state    = r_state;
        node_re    = 1'b0;
        node_raddr = r_k;
        feat_re    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (act == dti_pkg::ACT_CLASSIFY)) begin
                    node_re    = 1'b1;
                    node_raddr = '0;
                    n_state    = S_NODE;
                end
            end
            S_NODE: begin
                if (node.leaf) begin
                    n_state = S_MUL;
                end else if (step_lim) begin
                    n_state = S_OUT;
                end else begin
                    feat_re = 1'b1;
                    n_state = S_TEST;
                end
            end
            S_TEST: begin
                if (split.fault) begin
                    n_state = S_OUT;
                end else begin
                    node_re    = 1'b1;
                    node_raddr = split.next;
                    n_state    = S_NODE;
                end
            end
            S_MUL: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_steps     <= '0;
            r_fault     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (in_acc && (act == dti_pkg::ACT_CLASSIFY)) begin
                        r_k        <= '0;
                        r_steps    <= '0;
                        r_fault    <= 1'b0;
                        r_exposure <= in_exposure;
                    end
                end
                S_NODE: begin
                    if (!node.leaf) begin
                        if (step_lim) begin
                            r_fault <= 1'b1;
                        end else begin
                            r_steps <= r_steps + SW'(1);
                        end
                    end
                end
                S_TEST: begin
                    if (split.fault) begin
                        r_fault <= 1'b1;
                    end else begin
                        r_k <= split.next;
                    end
                end
                S_MUL: begin
                    r_prod <= 64'(node.rate) * 64'(r_exposure);
                end
                default: begin
                end
            endcase

            if (out_load) begin
                r_out_valid <= 1'b1;
                r_out_fault <= r_fault;
                r_out_pred  <= r_fault ? '0 : sat_pred;
                r_out_leaf  <= r_fault ? '0 : r_k;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_leaf, r_out_pred};
    assign m_axis_tuser  = r_out_fault;

    // a faulted beat carries no prediction and no leaf
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("faulted result with nonzero data");

    // walk counter never passes the interior node bound
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_steps <= StepLimit))
        else $error("walk step counter past bound");

    // a classify beat holds off the slave side on the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (act == dti_pkg::ACT_CLASSIFY)) |=> !s_axis_tready)
        else $error("slave side ready during walk");

    // the walk position stays inside the node table
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NODE) |-> (17'(r_k) < 17'(MAX_NODES)))
        else $error("walk position out of table");

endmodule

`default_nettype wire

/* rtl/dti_store.sv */
// ----------------------------------------------------------------------------
// dti_store
// Node table and sample feature memories. One write and one registered
// read port each; reads hold their data until the next read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module dti_store #(
    parameter int MAX_NODES    = 1024,
    parameter int NUM_FEATURES = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_node_we,
    input  wire logic [dti_pkg::IDX_W-1:0]     i_node_waddr,
    input  wire dti_pkg::t_node                i_node_wdata,
    input  wire logic                          i_node_re,
    input  wire logic [dti_pkg::IDX_W-1:0]     i_node_raddr,
    output dti_pkg::t_node                     o_node,
    input  wire logic                          i_feat_we,
    input  wire logic [dti_pkg::IDX_W-1:0]     i_feat_waddr,
    input  wire logic [dti_pkg::DATA_W-1:0]    i_feat_wdata,
    input  wire logic                          i_feat_re,
    input  wire logic [dti_pkg::FEAT_W-1:0]    i_feat_raddr,
    output logic [dti_pkg::DATA_W-1:0]         o_feat_value
);

    localparam int NodeDepth = (MAX_NODES < dti_pkg::IDX_SPACE) ? MAX_NODES
                                                                : dti_pkg::IDX_SPACE;
    localparam int NAW = (NodeDepth > 1) ? $clog2(NodeDepth) : 1;
    localparam int FAW = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
    localparam logic [16:0] MaxNodesW = 17'(MAX_NODES);
    localparam logic [10:0] NumFeatW  = 11'(NUM_FEATURES);

    dti_pkg::t_node              r_node_mem [NodeDepth];
    logic [dti_pkg::DATA_W-1:0]  r_feat_mem [NUM_FEATURES];
    dti_pkg::t_node              r_node;
    logic [dti_pkg::DATA_W-1:0]  r_feat;
    logic                        r_feat_ok;

    logic node_wr_ok;
    logic feat_wr_ok;

    assign node_wr_ok = 17'(i_node_waddr) < MaxNodesW;
    assign feat_wr_ok = 11'(i_feat_waddr) < NumFeatW;

    always_ff @(posedge i_clk) begin
        if (i_node_we && node_wr_ok) begin
            r_node_mem[i_node_waddr[NAW-1:0]] <= i_node_wdata;
        end
        if (i_node_re) begin
            r_node <= r_node_mem[i_node_raddr[NAW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_feat_we && feat_wr_ok) begin
            r_feat_mem[i_feat_waddr[FAW-1:0]] <= i_feat_wdata;
        end
        if (i_feat_re) begin
            r_feat    <= r_feat_mem[FAW'(i_feat_raddr)];
            // features past the sample width read as zero
            r_feat_ok <= 11'(i_feat_raddr) < NumFeatW;
        end
    end

    assign o_node       = r_node;
    assign o_feat_value = r_feat_ok ? r_feat : '0;

endmodule

`default_nettype wire

/* rtl/dti_split.sv */
// ----------------------------------------------------------------------------
// dti_split
// Split test unit shared by every node visit: numeric compare against the
// threshold or categorical mask lookup, child select and range checks.
// ----------------------------------------------------------------------------
`default_nettype none

module dti_split #(
    parameter int MAX_NODES      = 1024,
    parameter int MAX_CATEGORIES = 32
) (
    input  wire dti_pkg::t_node              i_node,
    input  wire logic [dti_pkg::DATA_W-1:0]  i_value,
    output dti_pkg::t_split                  o_split
);

    localparam int CatLimit = (MAX_CATEGORIES < 32) ? MAX_CATEGORIES : 32;
    localparam logic [14:0] CatLimitW = 15'(CatLimit);
    localparam logic [16:0] MaxNodesW = 17'(MAX_NODES);

    logic                      cat_ok;
    logic [4:0]                cat_bit;
    logic                      go_left;
    logic [dti_pkg::IDX_W-1:0] next;

    always_comb begin
        // code = floor(value / 2^16); valid range 1..CatLimit
        cat_ok  = !i_value[31] && (i_value[30:16] != '0) && (i_value[30:16] <= CatLimitW);
        // code 32 wraps to bit 31 in five bits
        cat_bit = i_value[20:16] - 5'd1;
        if (i_node.categorical) begin
            go_left = i_node.mask[cat_bit];
        end else begin
            go_left = $signed(i_value) <= $signed(i_node.threshold);
        end
        next            = go_left ? i_node.left : i_node.right;
        o_split.next    = next;
        o_split.fault   = (i_node.categorical && !cat_ok) || (17'(next) >= MaxNodesW);
    end

endmodule

`default_nettype wire

/* verif/decision_tree_inference_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// decision_tree_inference_tb
// Self-checking bench for the tree inference block. A directed table
// covers the extremes and each fault path: long walk, category code out of
// range, ignored writes and the unused action. Random tree loads then run
// classify beats with random gaps and stalls on both stream sides. Their
// results are checked against a walk of a shadow copy of the node table.
// ----------------------------------------------------------------------------
module decision_tree_inference_tb;

    localparam int ACT_W          = dti_pkg::ACT_W;
    localparam int IDX_W          = dti_pkg::IDX_W;
    localparam int FEAT_W         = dti_pkg::FEAT_W;
    localparam int DATA_W         = dti_pkg::DATA_W;
    localparam int S_TDATA_W      = dti_pkg::S_TDATA_W;
    localparam int M_TDATA_W      = dti_pkg::M_TDATA_W;
    localparam int MAX_NODES      = 1024;
    localparam int NUM_FEATURES   = 64;
    localparam int MAX_CATEGORIES = 32;
    localparam int N_ITEMS        = 1350;
    localparam int QUIET_TAIL     = 150;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_CYCLES   = 64;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int MAX_REPORTS    = 100;
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct {
        logic [ACT_W-1:0]  action;
        logic [IDX_W-1:0]  index;
        logic              leaf;
        logic              cat;
        logic [IDX_W-1:0]  left;
        logic [IDX_W-1:0]  right;
        logic [FEAT_W-1:0] feat;
        logic [DATA_W-1:0] thr;
        logic [DATA_W-1:0] mask;
        logic [DATA_W-1:0] rate;
        logic [DATA_W-1:0] fval;
        logic [DATA_W-1:0] expo;
    } t_req;

    typedef struct packed {
        logic [DATA_W-1:0] pred;
        logic [IDX_W-1:0]  leaf;
        logic              fault;
    } t_score;

    typedef struct {
        t_req   req;
        bit     typed;
        t_score want;
    } t_row;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [ACT_W-1:0]     s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b1;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tuser;

    // shadow of the node table and the sample
    dti_pkg::t_node    node_tab  [MAX_NODES];
    bit                node_seen [MAX_NODES];
    logic [DATA_W-1:0] feat_val  [NUM_FEATURES];
    bit                feat_seen [NUM_FEATURES];
    t_score            predictions_due [$];

    // features split on by the tree being loaded
    bit                feat_used [NUM_FEATURES];
    bit                feat_cat  [NUM_FEATURES];
    logic [DATA_W-1:0] feat_thr  [NUM_FEATURES];

    t_row dir_rows [$];
    int   n_errors = 0, n_reports = 0, n_results = 0, n_scored = 0;
    int   n_faults = 0, n_full = 0, n_beats = 0, n_counted = 0, n_trees = 0;
    int   stall_cycles = 0;
    bit   hold_req = 1'b0, tx_gaps = 1'b1, rx_gaps = 1'b1;

    decision_tree_inference #(
        .MAX_NODES      (MAX_NODES),
        .NUM_FEATURES   (NUM_FEATURES),
        .MAX_CATEGORIES (MAX_CATEGORIES)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // tdata, low bits first: index, leaf, categorical, left, right, feature,
    // threshold, mask, rate, feature value, exposure, zero pad
    function automatic logic [S_TDATA_W-1:0] pack_req(input t_req r);
        return S_TDATA_W'({r.expo, r.fval, r.rate, r.mask, r.thr, r.feat,
                           r.right, r.left, r.cat, r.leaf, r.index});
    endfunction

    // walks the shadow tree; clean drops when an unwritten node or feature entry is reached
    function automatic t_score score_sample(input logic [DATA_W-1:0] expo, output bit clean);
        int unsigned       k;
        int unsigned       steps;
        int                code;
        logic [DATA_W-1:0] v;
        logic              go_left;
        logic [63:0]       prod;
        t_score            r;
        r = '0;
        clean = 1'b1;
        k = 0;
        steps = 0;
        while (1) begin
            if (!node_seen[k]) begin
                clean = 1'b0;
                return r;
            end
            if (node_tab[k].leaf)
                break;
            if (steps >= MAX_NODES) begin
                r.fault = 1'b1;
                return r;
            end
            steps++;
            if (node_tab[k].feature < NUM_FEATURES) begin
                if (!feat_seen[node_tab[k].feature]) begin
                    clean = 1'b0;
                    return r;
                end
                v = feat_val[node_tab[k].feature];
            end else begin
                v = '0;
            end
            if (node_tab[k].categorical) begin
                code = $signed(v) >>> 16;   // floor of the Q16.16 value
                if (code < 1 || code > MAX_CATEGORIES || code > DATA_W) begin
                    r.fault = 1'b1;
                    return r;
                end
                go_left = node_tab[k].mask[code-1];
            end else begin
                go_left = $signed(v) <= $signed(node_tab[k].threshold);
            end
            k = 32'(go_left ? node_tab[k].left : node_tab[k].right);
            if (k >= MAX_NODES) begin
                r.fault = 1'b1;
                return r;
            end
        end
        prod = (64'(node_tab[k].rate) * 64'(expo)) >> 16;
        r.pred = (prod > 64'hFFFF_FFFF) ? '1 : prod[DATA_W-1:0];
        r.leaf = k[IDX_W-1:0];
        return r;
    endfunction

    function automatic t_req noise_req(input logic [ACT_W-1:0] act);
        t_req r;
        r.action = act;
        r.index  = IDX_W'($urandom);
        r.leaf   = 1'($urandom);
        r.cat    = 1'($urandom);
        r.left   = IDX_W'($urandom);
        r.right  = IDX_W'($urandom);
        r.feat   = FEAT_W'($urandom);
        r.thr    = $urandom;
        r.mask   = $urandom;
        r.rate   = $urandom;
        r.fval   = $urandom;
        r.expo   = $urandom;
        return r;
    endfunction

    function automatic t_req node_req(input logic [IDX_W-1:0] idx, input logic leaf,
                                      input logic cat, input logic [IDX_W-1:0] left,
                                      input logic [IDX_W-1:0] right,
                                      input logic [FEAT_W-1:0] feat,
                                      input logic [DATA_W-1:0] thr,
                                      input logic [DATA_W-1:0] mask,
                                      input logic [DATA_W-1:0] rate);
        t_req r;
        r = noise_req(dti_pkg::ACT_WR_NODE);
        r.index = idx;
        r.leaf  = leaf;
        r.cat   = cat;
        r.left  = left;
        r.right = right;
        r.feat  = feat;
        r.thr   = thr;
        r.mask  = mask;
        r.rate  = rate;
        return r;
    endfunction

    function automatic t_req feat_req(input logic [IDX_W-1:0] idx,
                                      input logic [DATA_W-1:0] val);
        t_req r;
        r = noise_req(dti_pkg::ACT_WR_FEAT);
        r.index = idx;
        r.fval  = val;
        return r;
    endfunction

    function automatic t_req score_req(input logic [DATA_W-1:0] expo);
        t_req r;
        r = noise_req(dti_pkg::ACT_CLASSIFY);
        r.expo = expo;
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 32'($urandom_range(0, 32'h0004_0000));
            3: return 32'd0 - 32'($urandom_range(0, 32'h0004_0000));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_mask();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_value(input int f);
        int code;
        if (feat_cat[f] && $urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 9))
                0: code = 0;
                1: code = MAX_CATEGORIES + int'($urandom_range(1, 8));
                2: code = 0 - int'($urandom_range(1, 4));
                default: code = $urandom_range(1, MAX_CATEGORIES);
            endcase
            return {code[15:0], 16'($urandom)};
        end
        case ($urandom_range(0, 3))
            0: return feat_thr[f];
            1: return feat_thr[f] + 32'($urandom_range(0, 2)) - 32'd1;
            2: return pick_word();
            default: return $urandom;
        endcase
    endfunction

    task automatic add_row(input t_req r, input bit typed = 1'b0,
                           input logic [DATA_W-1:0] pred = '0,
                           input logic [IDX_W-1:0] leaf = '0, input logic fault = 1'b0);
        t_row row;
        row.req   = r;
        row.typed = typed;
        row.want  = '{pred: pred, leaf: leaf, fault: fault};
        dir_rows.push_back(row);
    endtask

    task automatic commit_beat(input t_req it, input bit typed, input t_score typed_score);
        bit     clean;
        t_score s;
        n_beats++;
        case (it.action)
            dti_pkg::ACT_WR_NODE: begin
                if (it.index < MAX_NODES) begin
                    node_tab[it.index] = '{leaf: it.leaf, categorical: it.cat,
                                           left: it.left, right: it.right,
                                           feature: it.feat, threshold: it.thr,
                                           mask: it.mask, rate: it.rate};
                    node_seen[it.index] = 1'b1;
                    n_counted++;
                end
            end
            dti_pkg::ACT_WR_FEAT: begin
                if (it.index < NUM_FEATURES) begin
                    feat_val[it.index]  = it.fval;
                    feat_seen[it.index] = 1'b1;
                    n_counted++;
                end
            end
            dti_pkg::ACT_CLASSIFY: begin
                s = score_sample(it.expo, clean);
                if (typed)
                    s = typed_score;
                predictions_due.push_back(s);
                n_scored++;
                n_counted++;
                if (s.fault)
                    n_faults++;
                else if (s.pred == '1)
                    n_full++;
            end
            default: ;
        endcase
    endtask

    task automatic send_beat(input t_req it, input bit typed = 1'b0,
                             input t_score typed_score = '0);
        int gap;
        if (tx_gaps && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 7);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_req(it);
        s_axis_tuser  <= it.action;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        commit_beat(it, typed, typed_score);
    endtask

    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (predictions_due.size() != 0) @(posedge i_clk);
    endtask

    // a classify is only sent when its walk stays on written entries
    task automatic classify_if_defined(input logic [DATA_W-1:0] expo);
        bit     clean;
        t_score probe;
        probe = score_sample(expo, clean);
        if (clean)
            send_beat(score_req(expo));
    endtask

    task automatic send_noise();
        t_req r;
        r = noise_req(dti_pkg::ACT_WR_FEAT);
        case ($urandom_range(0, 3))
            0: send_beat(noise_req(ACT_UNUSED));
            1: begin
                r.index = IDX_W'($urandom_range(NUM_FEATURES, 2**IDX_W - 1));
                send_beat(r);
            end
            2: send_beat(noise_req(dti_pkg::ACT_WR_NODE));   // may reshape the current tree
            default: classify_if_defined(r.expo);
        endcase
    endtask

    // breadth-first build from the root; a looped tree may have links back to 0
    task automatic load_tree(input int budget, input bit looped);
        bit               taken [MAX_NODES];
        int unsigned      pending [$];
        t_req             nodes [$];
        t_req             tmp;
        int unsigned      k;
        int unsigned      c;
        int               j;
        logic [IDX_W-1:0] kid [2];
        bit               interior;
        foreach (feat_used[f]) begin
            feat_used[f] = 1'b0;
            feat_cat[f]  = 1'b0;
            feat_thr[f]  = '0;
        end
        pending.push_back(0);
        taken[0] = 1'b1;
        while (pending.size() > 0) begin
            k = pending.pop_front();
            interior = budget > 0 && (k == 0 || $urandom_range(0, 3) != 0);
            tmp = node_req(IDX_W'(k), !interior, $urandom_range(0, 2) == 0,
                           IDX_W'($urandom), IDX_W'($urandom),
                           FEAT_W'($urandom_range(0, NUM_FEATURES - 1)), pick_word(),
                           pick_mask(), pick_word());
            if (interior) begin
                budget--;
                for (j = 0; j < 2; j++) begin
                    if (looped && $urandom_range(0, 5) == 0) begin
                        kid[j] = '0;
                    end else begin
                        do begin
                            c = $urandom_range(1, MAX_NODES - 1);
                        end while (taken[c]);
                        taken[c] = 1'b1;
                        pending.push_back(c);
                        kid[j] = IDX_W'(c);
                    end
                end
                tmp.left  = kid[0];
                tmp.right = kid[1];
                feat_used[tmp.feat] = 1'b1;
                if (tmp.cat)
                    feat_cat[tmp.feat] = 1'b1;
                else
                    feat_thr[tmp.feat] = tmp.thr;
            end
            nodes.push_back(tmp);
        end
        for (j = nodes.size() - 1; j > 0; j--) begin
            c = $urandom_range(0, j);
            tmp = nodes[j];
            nodes[j] = nodes[c];
            nodes[c] = tmp;
        end
        foreach (nodes[i])
            send_beat(nodes[i]);
        n_trees++;
    endtask

    task automatic run_samples(input int n_samples);
        int s;
        int f;
        for (s = 0; s < n_samples; s++) begin
            for (f = 0; f < NUM_FEATURES; f++)
                if (feat_used[f] && (s == 0 || $urandom_range(0, 1) == 0))
                    send_beat(feat_req(IDX_W'(f), pick_value(f)));
            if ($urandom_range(0, 5) == 0)
                send_noise();
            classify_if_defined(pick_word());
        end
    endtask

    initial begin : stimulus
        int  phase;
        bit  quiet;
        int  budget;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // numeric root: leaf 1 holds rate 1.0 on the left, leaf 1022 full scale on the right
        add_row(node_req(0, 1'b0, 1'b0, 1, 1022, 0, 32'h0, 32'h0, 32'h0));
        add_row(node_req(1, 1'b1, 1'b0, 0, 0, 0, 32'h0, 32'h0, 32'h0001_0000));
        add_row(node_req(1022, 1'b1, 1'b0, 1023, 1023, 63, '1, '1, '1));
        add_row(feat_req(0, 32'h0));
        add_row(score_req(32'h0001_0000), 1'b1, 32'h0001_0000, 1, 1'b0);
        add_row(feat_req(0, 32'h0000_0001));
        add_row(score_req('1), 1'b1, '1, 1022, 1'b0);
        add_row(feat_req(0, 32'h8000_0000));
        add_row(score_req('0), 1'b1, '0, 1, 1'b0);
        add_row(node_req(0, 1'b0, 1'b0, 1022, 1, 63, 32'h7FFF_FFFF, 32'h0, 32'h0));
        add_row(feat_req(63, 32'h7FFF_FFFF));
        add_row(score_req(32'h0001_0000), 1'b1, '1, 1022, 1'b0);
        // categorical root on feature 1: categories 1 and 32 go left
        add_row(node_req(0, 1'b0, 1'b1, 1, 1022, 1, 32'h0, 32'h8000_0001, 32'h0));
        add_row(feat_req(1, 32'h0001_8000));
        add_row(score_req(32'h0003_0000), 1'b1, 32'h0003_0000, 1, 1'b0);
        add_row(feat_req(1, 32'h0020_0000));
        add_row(score_req(32'h0000_8000), 1'b1, 32'h0000_8000, 1, 1'b0);
        add_row(feat_req(1, 32'h0021_0000));
        add_row(score_req($urandom), 1'b1, '0, 0, 1'b1);
        add_row(feat_req(1, 32'hFFFF_8000));   // -0.5 floors to category -1
        add_row(score_req($urandom), 1'b1, '0, 0, 1'b1);
        add_row(noise_req(ACT_UNUSED));
        add_row(feat_req(1000, $urandom));
        // root points at itself: the walk can never reach a leaf
        add_row(node_req(0, 1'b0, 1'b0, 0, 0, 0, $urandom, $urandom, $urandom));
        add_row(score_req($urandom), 1'b1, '0, 0, 1'b1);
        foreach (dir_rows[i])
            send_beat(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

        phase = 0;
        while (n_counted < N_ITEMS) begin
            quiet   = n_counted >= N_ITEMS - QUIET_TAIL;
            tx_gaps = !quiet && $urandom_range(0, 3) != 0;
            rx_gaps = !quiet && $urandom_range(0, 3) != 0;
            if (phase == 6)
                hold_req = 1'b1;   // results back up while beats keep coming
            if (phase == 10)
                wait_for_drain();
            budget = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 60)
                                                 : $urandom_range(1, 8);
            load_tree(budget, $urandom_range(0, 24) == 0);
            run_samples($urandom_range(2, 8));
            phase++;
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Run: %0d beats in, %0d tree loads, %0d results checked.",
                 n_beats, n_trees, n_results);
        $display("Of %0d classifies, %0d faulted and %0d came out at full scale.",
                 n_scored, n_faults, n_full);
        if (n_errors == 0 && predictions_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin : result_sink
        int gap;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
                gap = $urandom_range(1, 7);
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_score want;
        t_score got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.pred  = m_axis_tdata[DATA_W-1:0];
            got.leaf  = m_axis_tdata[DATA_W +: IDX_W];
            got.fault = m_axis_tuser;
            if (predictions_due.size() == 0) begin
                n_errors++;
                if (n_reports < MAX_REPORTS) begin
                    n_reports++;
                    $display("%0t: result beat with none expected: pred %h leaf %0d fault %b",
                             $time, got.pred, got.leaf, got.fault);
                end
            end else begin
                want = predictions_due.pop_front();
                n_results++;
                if (got.pred !== want.pred || got.leaf !== want.leaf ||
                    got.fault !== want.fault) begin
                    n_errors++;
                    if (n_reports < MAX_REPORTS) begin
                        n_reports++;
                        $display("%0t: expected pred %h leaf %0d fault %b, got %h %0d %b",
                                 $time, want.pred, want.leaf, want.fault,
                                 got.pred, got.leaf, got.fault);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule

/* filelist.f */
rtl/dti_pkg.sv
rtl/dti_store.sv
rtl/dti_split.sv
rtl/decision_tree_inference.sv
verif/decision_tree_inference_tb.sv
